[rtl/t7x_pkg.sv]
// Package with the word types, codes, key table and helper functions of the type 7 codec.
`default_nettype none
package t7x_pkg;

  localparam int MAX_CHARS   = 11;
  localparam int TABLE_LEN   = 53;
  localparam int KIDX_W      = 6;
  localparam int CCNT_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SEED_NUM_W  = 10;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_CHAR  = 1'b1
  } kind_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ODD = 1'b1;

  localparam logic [1:0] SEED_NONE = 2'd0;
  localparam logic [1:0] SEED_ONE  = 2'd1;
  localparam logic [1:0] SEED_DONE = 2'd2;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_LA   = 8'h61;
  localparam logic [7:0] ASCII_LF   = 8'h66;
  localparam logic [7:0] ASCII_UA   = 8'h41;
  localparam logic [7:0] ASCII_UF   = 8'h46;

  localparam logic [7:0] KEY_TABLE [64] = '{
    8'h64, 8'h73, 8'h66, 8'h64, 8'h3b, 8'h6b, 8'h66, 8'h6f,
    8'h41, 8'h2c, 8'h2e, 8'h69, 8'h79, 8'h65, 8'h77, 8'h72,
    8'h6b, 8'h6c, 8'h64, 8'h4a, 8'h4b, 8'h44, 8'h48, 8'h53,
    8'h55, 8'h42, 8'h73, 8'h67, 8'h76, 8'h63, 8'h61, 8'h36,
    8'h39, 8'h38, 8'h33, 8'h34, 8'h6e, 8'h63, 8'h78, 8'h76,
    8'h39, 8'h38, 8'h37, 8'h33, 8'h32, 8'h35, 8'h34, 8'h6b,
    8'h3b, 8'h66, 8'h67, 8'h38, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  seed_in;
    logic [7:0]  data_in;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        status;
    logic        last_out;
  } out_word_t;

  typedef struct packed {
    logic        two;
    out_word_t   first;
    out_word_t   second;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = ASCII_ZERO + {4'd0, n};
    end else begin
      c = ASCII_LA + {4'd0, n} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      v = c - ASCII_ZERO;
    end else if (c >= ASCII_LA && c <= ASCII_LF) begin
      v = c - ASCII_LA + 8'd10;
    end else if (c >= ASCII_UA && c <= ASCII_UF) begin
      v = c - ASCII_UA + 8'd10;
    end
    return v[3:0];
  endfunction

  // Restoring reduction by shifted multiples of the table length.
  function automatic logic [KIDX_W-1:0] mod_table(input logic [SEED_NUM_W-1:0] val);
    logic [SEED_NUM_W+KIDX_W-1:0] r;
    logic [SEED_NUM_W+KIDX_W-1:0] m;
    r = {{KIDX_W{1'b0}}, val};
    for (int k = KIDX_W - 1; k >= 0; k--) begin
      m = (SEED_NUM_W + KIDX_W)'(TABLE_LEN) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[KIDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/type7_password_xor_codec_top.sv]
// Top level of the type 7 password XOR codec.
// Input words (in_valid/in_ready/in_data) are either a begin word, which opens
// a record, or a character word; in_data.last_in closes the record.
// cfg_we with cfg_wdata selects encoding (0) or decoding (1); it must be written
// only while the block is idle, which the block itself does not enforce.
// Each accepted word gives zero, one or two result words on out_valid,
// out_ready and out_data. The job built from an accepted word is registered in
// the job queue, and its first result word is offered once it reaches the head.
// A word is accepted in every cycle while the two-entry job queue has room.
// The output stage sends one result word per cycle while out_ready is high, so
// encode character words and encode begin words, which give two result words,
// cannot be sustained at the input rate; decode words sustain one per cycle.
// When the receiver stalls, the queue fills and in_ready falls once it holds
// two jobs; nothing is lost.
// Reset clears the record state, selects encoding and empties the queue.
`default_nettype none
module type7_password_xor_codec_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [0:0]           cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  t7x_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output t7x_pkg::out_word_t   out_data
);
  import t7x_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_job, q_head;

  t7x_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  t7x_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  t7x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/t7x_front.sv]
// Front end: accepts input words, keeps the record state and builds result jobs.
`default_nettype none
module t7x_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [0:0]             cfg_wdata,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  t7x_pkg::in_word_t      in_data,
  input  wire                    q_full,
  output logic                   q_push,
  output t7x_pkg::job_t          q_job
);
  import t7x_pkg::*;

  dir_t              dir_r;
  logic [KIDX_W-1:0] key_idx_r, key_idx_nxt;
  logic [CCNT_W-1:0] char_cnt_r, char_cnt_nxt;
  logic [1:0]        seed_seen_r, seed_seen_nxt;
  logic [3:0]        high_nib_r, high_nib_nxt;
  logic              nib_pend_r, nib_pend_nxt;
  logic              stopped_r, stopped_nxt;

  logic [KIDX_W:0]   key_inc;
  logic [KIDX_W-1:0] key_adv;
  logic [7:0]        key_byte;
  logic [7:0]        xv;
  logic [3:0]        nib;
  logic [3:0]        dig;
  logic [3:0]        seed_lo;
  logic [1:0]        n;
  logic              accept;
  out_word_t         r0, r1;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign key_byte = KEY_TABLE[key_idx_r];
  assign key_inc  = {1'b0, key_idx_r} + (KIDX_W+1)'(1);
  assign key_adv  = (key_inc >= (KIDX_W+1)'(TABLE_LEN)) ? '0 : key_inc[KIDX_W-1:0];
  assign nib      = hex_value(in_data.data_in);
  assign dig      = (in_data.data_in >= ASCII_ZERO && in_data.data_in <= ASCII_NINE) ?
                    4'(in_data.data_in - ASCII_ZERO) : 4'd0;
  assign seed_lo  = (in_data.seed_in >= 4'd10) ? in_data.seed_in - 4'd10 : in_data.seed_in;

  always_comb begin
    key_idx_nxt   = key_idx_r;
    char_cnt_nxt  = char_cnt_r;
    seed_seen_nxt = seed_seen_r;
    high_nib_nxt  = high_nib_r;
    nib_pend_nxt  = nib_pend_r;
    stopped_nxt   = stopped_r;
    r0            = '0;
    r1            = '0;
    n             = 2'd0;
    xv            = '0;
    if (in_data.kind == KIND_BEGIN) begin
      char_cnt_nxt = '0;
      nib_pend_nxt = 1'b0;
      high_nib_nxt = '0;
      stopped_nxt  = in_data.last_in;
      if (dir_r == DIR_ENCODE) begin
        key_idx_nxt   = {{(KIDX_W-4){1'b0}}, in_data.seed_in};
        seed_seen_nxt = SEED_DONE;
        r0.data_out   = (in_data.seed_in >= 4'd10) ? ASCII_ONE : ASCII_ZERO;
        r1.data_out   = ASCII_ZERO + {4'd0, seed_lo};
        r1.last_out   = in_data.last_in;
        n             = 2'd2;
      end else begin
        key_idx_nxt   = '0;
        seed_seen_nxt = SEED_NONE;
        if (in_data.last_in) begin
          r0.last_out = 1'b1;
          n           = 2'd1;
        end
      end
    end else begin
      if (!stopped_r) begin
        if (dir_r == DIR_ENCODE) begin
          if (in_data.data_in == 8'd0) begin
            stopped_nxt = 1'b1;
          end else if (char_cnt_r < CCNT_W'(MAX_CHARS)) begin
            xv           = in_data.data_in ^ key_byte;
            key_idx_nxt  = key_adv;
            char_cnt_nxt = char_cnt_r + CCNT_W'(1);
            r0.data_out  = hex_char(xv[7:4]);
            r1.data_out  = hex_char(xv[3:0]);
            r1.last_out  = in_data.last_in;
            n            = 2'd2;
          end
        end else if (seed_seen_r != SEED_DONE) begin
          if (seed_seen_r == SEED_NONE) begin
            key_idx_nxt   = {{(KIDX_W-4){1'b0}}, dig};
            seed_seen_nxt = SEED_ONE;
          end else begin
            key_idx_nxt   = mod_table(SEED_NUM_W'(key_idx_r) * SEED_NUM_W'(10)
                                      + SEED_NUM_W'(dig));
            seed_seen_nxt = SEED_DONE;
          end
        end else if (char_cnt_r < CCNT_W'(MAX_CHARS)) begin
          if (!nib_pend_r) begin
            high_nib_nxt = nib;
            nib_pend_nxt = 1'b1;
            if (in_data.last_in) begin
              r0.status   = STAT_ODD;
              r0.last_out = 1'b1;
              n           = 2'd1;
            end
          end else begin
            xv           = {high_nib_r, nib} ^ key_byte;
            key_idx_nxt  = key_adv;
            char_cnt_nxt = char_cnt_r + CCNT_W'(1);
            nib_pend_nxt = 1'b0;
            r0.data_out  = xv;
            r0.last_out  = in_data.last_in;
            n            = 2'd1;
          end
        end
      end
      if (in_data.last_in) begin
        stopped_nxt = 1'b1;
        if (n == 2'd0) begin
          r0.last_out = 1'b1;
          n           = 2'd1;
        end
      end
    end
  end

  assign q_push       = accept && (n != 2'd0);
  assign q_job.two    = (n == 2'd2);
  assign q_job.first  = r0;
  assign q_job.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_ENCODE;
      key_idx_r   <= '0;
      char_cnt_r  <= '0;
      seed_seen_r <= SEED_NONE;
      high_nib_r  <= '0;
      nib_pend_r  <= 1'b0;
      stopped_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        dir_r <= dir_t'(cfg_wdata[0]);
      end
      if (accept) begin
        key_idx_r   <= key_idx_nxt;
        char_cnt_r  <= char_cnt_nxt;
        seed_seen_r <= seed_seen_nxt;
        high_nib_r  <= high_nib_nxt;
        nib_pend_r  <= nib_pend_nxt;
        stopped_r   <= stopped_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/t7x_queue.sv]
// Short job queue between the front end and the output stage.
`default_nettype none
module t7x_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  t7x_pkg::job_t      push_job,
  input  wire                pop,
  output logic               full,
  output logic               empty,
  output t7x_pkg::job_t      head
);
  import t7x_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/t7x_back.sv]
// Output stage: sends the one or two result words of each queued job in turn.
`default_nettype none
module t7x_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  t7x_pkg::job_t        q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output t7x_pkg::out_word_t   out_data
);
  import t7x_pkg::*;

  logic second_r;

  assign out_valid = !q_empty;
  assign out_data  = second_r ? q_head.second : q_head.first;
  assign q_pop     = out_valid && out_ready && (second_r || !q_head.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      second_r <= !second_r && q_head.two;
    end
  end

endmodule
`default_nettype wire
